[rtl/core/tfd_pkg.sv]
// Shared types and constants for the telematics frame deframer.
`default_nettype none
package tfd_pkg;

  localparam int unsigned IdLengthDefault = 17;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QueuePtrW       = $clog2(QueueDepth);

  localparam logic [7:0] StartByte = 8'h23;
  localparam logic [7:0] EncMin    = 8'h01;
  localparam logic [7:0] EncMax    = 8'h03;

  typedef enum logic [3:0] {
    PH_S0, PH_S1, PH_CMD, PH_RESP, PH_ID, PH_ENC, PH_LENH, PH_LENL, PH_PAY, PH_CHECK
  } phase_e;

  typedef enum logic [2:0] {
    KIND_CMD, KIND_RESP, KIND_ID, KIND_ENC, KIND_LENH, KIND_LENL, KIND_PAY, KIND_STATUS
  } field_kind_e;

  typedef enum logic [2:0] {
    ST_OK, ST_BADSTART, ST_TRUNC, ST_CSUM, ST_ENC
  } frame_status_e;

  // One queue entry: an optional field item followed by an optional status item.
  typedef struct packed {
    logic          has_field;
    field_kind_e   kind;
    logic [7:0]    value;
    logic          has_status;
    frame_status_e status;
  } res_entry_t;

endpackage
`default_nettype wire

[rtl/core/tfd_front.sv]
// Front end: parses input bytes and produces result entries for the queue.
`default_nettype none
module tfd_front #(
  parameter int unsigned ID_LENGTH = tfd_pkg::IdLengthDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic [7:0]          byte_i,
  input  wire logic                eob_i,
  input  wire logic                queue_full_i,
  output logic                     push_o,
  output tfd_pkg::res_entry_t      entry_o
);
  import tfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  xor_q, xor_d;
  logic        done_q, done_d;
  logic        start_bad_q, start_bad_d;
  logic        enc_bad_q, enc_bad_d;

  logic        accept;
  logic        kind_vld;
  field_kind_e kind;
  logic        closing;
  frame_status_e status;
  logic [15:0] pos_inc;

  assign ready_o = !queue_full_i;
  assign accept  = valid_i && ready_o;
  assign pos_inc = pos_q + 16'd1;

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    len_d       = len_q;
    xor_d       = xor_q;
    done_d      = done_q;
    start_bad_d = start_bad_q;
    enc_bad_d   = enc_bad_q;
    kind_vld    = 1'b0;
    kind        = KIND_CMD;
    closing     = 1'b0;
    status      = ST_OK;
    push_o      = 1'b0;
    entry_o     = '0;

    if (accept && !done_q) begin
      if (phase_q >= PH_CMD && phase_q <= PH_PAY) begin
        xor_d = xor_q ^ byte_i;
      end
      unique case (phase_q)
        PH_S0: begin
          if (byte_i != StartByte) start_bad_d = 1'b1;
          phase_d = PH_S1;
        end
        PH_S1: begin
          if (byte_i != StartByte) start_bad_d = 1'b1;
          phase_d = PH_CMD;
        end
        PH_CMD: begin
          kind_vld = 1'b1;
          kind     = KIND_CMD;
          phase_d  = PH_RESP;
        end
        PH_RESP: begin
          kind_vld = 1'b1;
          kind     = KIND_RESP;
          pos_d    = '0;
          phase_d  = PH_ID;
        end
        PH_ID: begin
          kind_vld = 1'b1;
          kind     = KIND_ID;
          pos_d    = pos_inc;
          if (pos_inc >= 16'(ID_LENGTH)) begin
            pos_d   = '0;
            phase_d = PH_ENC;
          end
        end
        PH_ENC: begin
          kind_vld  = 1'b1;
          kind      = KIND_ENC;
          enc_bad_d = (byte_i < EncMin) || (byte_i > EncMax);
          phase_d   = PH_LENH;
        end
        PH_LENH: begin
          kind_vld = 1'b1;
          kind     = KIND_LENH;
          len_d    = {byte_i, 8'h00};
          phase_d  = PH_LENL;
        end
        PH_LENL: begin
          kind_vld = 1'b1;
          kind     = KIND_LENL;
          len_d    = {len_q[15:8], byte_i};
          pos_d    = '0;
          if (start_bad_q) begin
            closing = 1'b1;
            status  = ST_BADSTART;
          end else begin
            phase_d = (len_d != 16'd0) ? PH_PAY : PH_CHECK;
          end
        end
        PH_PAY: begin
          kind_vld = 1'b1;
          kind     = KIND_PAY;
          pos_d    = pos_inc;
          if (pos_inc >= len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          closing = 1'b1;
          if (enc_bad_q)            status = ST_ENC;
          else if (xor_q != byte_i) status = ST_CSUM;
          else                      status = ST_OK;
        end
        default: phase_d = PH_S0;
      endcase

      entry_o.has_field = kind_vld && !start_bad_q;
      entry_o.kind      = kind;
      entry_o.value     = byte_i;
      if (closing) begin
        entry_o.has_status = 1'b1;
        entry_o.status     = status;
        done_d             = 1'b1;
      end else if (eob_i) begin
        entry_o.has_status = 1'b1;
        entry_o.status     = ST_TRUNC;
        done_d             = 1'b1;
      end
      push_o = entry_o.has_field || entry_o.has_status;
    end

    // End of buffer returns the parser to its reset state.
    if (accept && eob_i) begin
      phase_d     = PH_S0;
      pos_d       = '0;
      len_d       = '0;
      xor_d       = '0;
      done_d      = 1'b0;
      start_bad_d = 1'b0;
      enc_bad_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_S0;
      pos_q       <= '0;
      len_q       <= '0;
      xor_q       <= '0;
      done_q      <= 1'b0;
      start_bad_q <= 1'b0;
      enc_bad_q   <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      xor_q       <= xor_d;
      done_q      <= done_d;
      start_bad_q <= start_bad_d;
      enc_bad_q   <= enc_bad_d;
    end
  end

endmodule
`default_nettype wire

[rtl/core/tfd_queue.sv]
// Short FIFO of result entries between the parser and the output stage.
`default_nettype none
module tfd_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire tfd_pkg::res_entry_t entry_i,
  input  wire logic                pop_i,
  output tfd_pkg::res_entry_t      entry_o,
  output logic                     empty_o,
  output logic                     full_o
);
  import tfd_pkg::*;

  res_entry_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign entry_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/core/tfd_back.sv]
// Output stage: drains queue entries and issues one result item per cycle while ready_i is high.
`default_nettype none
module tfd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tfd_pkg::res_entry_t entry_i,
  input  wire logic                empty_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic [2:0]               field_kind_o,
  output logic [7:0]               byte_value_o,
  output logic [2:0]               frame_status_o,
  output logic                     last_o
);
  import tfd_pkg::*;

  res_entry_t cur_q, cur_d;
  logic       vld_q, vld_d;
  logic       free;

  // The slot frees when empty, or when its final item leaves.
  always_comb begin
    cur_d = cur_q;
    vld_d = vld_q;
    free  = !vld_q;
    if (vld_q && ready_i) begin
      if (cur_q.has_field && cur_q.has_status) begin
        cur_d.has_field = 1'b0;
      end else begin
        free = 1'b1;
      end
    end
    pop_o = free && !empty_i;
    if (free) begin
      vld_d = !empty_i;
      cur_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  assign valid_o = vld_q;

  always_comb begin
    if (cur_q.has_field) begin
      field_kind_o   = cur_q.kind;
      byte_value_o   = cur_q.value;
      frame_status_o = ST_OK;
      last_o         = 1'b0;
    end else begin
      field_kind_o   = KIND_STATUS;
      byte_value_o   = 8'h00;
      frame_status_o = cur_q.status;
      last_o         = 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/telematics_frame_deframer.sv]
// Top level of the telematics frame deframer.
`default_nettype none
// Parses a received buffer streamed one byte per item on the slave side (tlast
// marks the buffer's final byte). A frame is two 0x23 start bytes, command,
// response flag, ID_LENGTH identifier characters, encryption method, a
// big-endian 16-bit payload length, the payload and one XOR checksum byte
// covering command through payload. Each byte from command through payload
// comes back as a result item tagged by its kind on tuser; the frame closes
// with a status item (kind 7, tlast high): ok, bad start, truncated, checksum
// mismatch, or unsupported encryption (which outranks a checksum mismatch). A
// bad start byte suppresses all field items and reports on the low length
// byte. Bytes after a closed frame are dropped until the buffer ends; the
// buffer end always resets the parser. Throughput: one input byte per cycle
// while the queue is not full. The parser feeds a four-entry queue; an input
// byte that yields both a field and a status item leaves as two output items,
// so the output port's one item per cycle, when not stalled, sets the sustained
// rate when such bytes cluster. Entries pass the queue and a registered slot.
module telematics_frame_deframer #(
  parameter int unsigned ID_LENGTH = tfd_pkg::IdLengthDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] byte_value, [10:8] frame_status,
                                           // [15:11] zero
  output logic [2:0]       m_axis_tuser,   // [2:0] field_kind
  output logic             m_axis_tlast    // last
);
  import tfd_pkg::*;

  logic       push, pop, q_empty, q_full;
  res_entry_t push_entry, head_entry;
  logic [7:0] byte_value;
  logic [2:0] frame_status;

  // Classify each byte and build its result entry.
  tfd_front #(
    .ID_LENGTH(ID_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .eob_i        (s_axis_tlast),
    .queue_full_i (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Decouple parser from output backpressure.
  tfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Serialize each entry into one or two output items.
  tfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .entry_i        (head_entry),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .field_kind_o   (m_axis_tuser),
    .byte_value_o   (byte_value),
    .frame_status_o (frame_status),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b00000, frame_status, byte_value};

endmodule
`default_nettype wire

[verif/telematics_frame_deframer_tb.sv]
// Self-checking testbench for the telematics frame deframer.
`timescale 1ns / 1ps
module telematics_frame_deframer_tb;
  import tfd_pkg::*;

  localparam int unsigned IdLen      = IdLengthDefault;
  localparam int unsigned HeaderLen  = 4 + IdLen + 3;   // start x2, cmd, resp, id, enc, len x2
  localparam int unsigned HoldCycles = 150;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned PhaseBytes = 60;

  // One result item as it should appear on the master side.
  typedef struct {
    field_kind_e   kind;
    logic [7:0]    value;
    frame_status_e status;
    logic          last;
  } frame_item_t;

  // Tracks the parser state for every accepted byte and holds the items it implies.
  class frame_scoreboard;
    frame_item_t   expected_q[$];
    int unsigned   errors;
    phase_e        ph;
    logic [15:0]   pos;
    logic [15:0]   pay_len;
    logic [7:0]    xsum;
    bit            closed;
    bit            start_bad;
    bit            enc_bad;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      ph        = PH_S0;
      pos       = '0;
      pay_len   = '0;
      xsum      = '0;
      closed    = 1'b0;
      start_bad = 1'b0;
      enc_bad   = 1'b0;
    endfunction

    function void push_item(field_kind_e k, logic [7:0] v, frame_status_e st, logic l);
      frame_item_t it;
      it.kind   = k;
      it.value  = v;
      it.status = st;
      it.last   = l;
      expected_q = {expected_q, it};
    endfunction

    function void note_byte(logic [7:0] b, logic eob);
      bit            has_field;
      field_kind_e   k;
      bit            closing;
      frame_status_e st;
      has_field = 1'b0;
      k         = KIND_CMD;
      closing   = 1'b0;
      st        = ST_OK;
      // Drop everything after a closed frame until the buffer ends.
      if (closed) begin
        if (eob) clear();
        return;
      end
      if (ph >= PH_CMD && ph <= PH_PAY) xsum = xsum ^ b;
      case (ph)
        PH_S0: begin
          if (b != StartByte) start_bad = 1'b1;
          ph = PH_S1;
        end
        PH_S1: begin
          if (b != StartByte) start_bad = 1'b1;
          ph = PH_CMD;
        end
        PH_CMD: begin
          has_field = 1'b1; k = KIND_CMD;
          ph = PH_RESP;
        end
        PH_RESP: begin
          has_field = 1'b1; k = KIND_RESP;
          pos = '0;
          ph = PH_ID;
        end
        PH_ID: begin
          has_field = 1'b1; k = KIND_ID;
          pos = pos + 16'd1;
          if (pos >= IdLen[15:0]) begin
            pos = '0;
            ph = PH_ENC;
          end
        end
        PH_ENC: begin
          has_field = 1'b1; k = KIND_ENC;
          enc_bad = (b < EncMin || b > EncMax);
          ph = PH_LENH;
        end
        PH_LENH: begin
          has_field = 1'b1; k = KIND_LENH;
          pay_len = {b, 8'h00};
          ph = PH_LENL;
        end
        PH_LENL: begin
          has_field = 1'b1; k = KIND_LENL;
          pay_len = pay_len | {8'h00, b};
          pos = '0;
          // A bad start byte reports here, once the fixed header is complete.
          if (start_bad) begin
            closing = 1'b1;
            st = ST_BADSTART;
          end else begin
            ph = (pay_len != 0) ? PH_PAY : PH_CHECK;
          end
        end
        PH_PAY: begin
          has_field = 1'b1; k = KIND_PAY;
          pos = pos + 16'd1;
          if (pos >= pay_len) ph = PH_CHECK;
        end
        PH_CHECK: begin
          closing = 1'b1;
          // Unsupported encryption outranks a checksum mismatch.
          if (enc_bad)        st = ST_ENC;
          else if (xsum != b) st = ST_CSUM;
          else                st = ST_OK;
        end
        default: ph = PH_S0;
      endcase
      if (has_field && !start_bad) push_item(k, b, ST_OK, 1'b0);
      if (closing) begin
        push_item(KIND_STATUS, 8'h00, st, 1'b1);
        closed = 1'b1;
      end else if (eob) begin
        push_item(KIND_STATUS, 8'h00, ST_TRUNC, 1'b1);
        closed = 1'b1;
      end
      if (eob) clear();
    endfunction

    function void check_item(logic [2:0] u, logic [15:0] d, logic l);
      frame_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item: kind=%0d value=%02h status=%0d last=%0b",
                 $time, u, d[7:0], d[10:8], l);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (u !== e.kind || d[7:0] !== e.value || d[10:8] !== e.status ||
          d[15:11] !== 5'b00000 || l !== e.last) begin
        $display("%0t: mismatch: expected kind=%0d value=%02h status=%0d last=%0b pad=0",
                 $time, e.kind, e.value, e.status, e.last);
        $display("%0t:           actual   kind=%0d value=%02h status=%0d last=%0b pad=%0d",
                 $time, u, d[7:0], d[10:8], l, d[15:11]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] byte_in
  logic        s_axis_tlast  = 1'b0;    // end_of_buffer
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [7:0] value, [10:8] status, [15:11] zero
  logic [2:0]  m_axis_tuser;            // [2:0] kind
  logic        m_axis_tlast;            // last

  frame_scoreboard sb = new();

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned bytes_sent = 0;
  int unsigned hold_reqs = 0;     // written by the stimulus only
  int unsigned holds_taken = 0;   // written by the receiver only
  int unsigned hold_left = 0;

  telematics_frame_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Sample both handshakes at the rising edge; inputs are noted before outputs are checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) sb.check_item(m_axis_tuser, m_axis_tdata,
                                                        m_axis_tlast);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the stimulus requests one.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_reqs != holds_taken) begin
        holds_taken++;
        hold_left = HoldCycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Watchdog: end the run if neither side moves an item for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("telematics_frame_deframer_tb: FAIL");
    $finish;
  end

  // Offer one byte; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Build one buffer around a frame and stream it. A cut index ends the buffer early;
  // otherwise tail_len trailing bytes follow the checksum.
  task automatic send_frame(input bit bad_start, input bit bad_enc, input bit bad_sum,
                            input int unsigned len, input int cut, input int unsigned tail_len);
    logic [7:0] bytes_q[$];
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'h00;
    bytes_q = {bytes_q, StartByte};
    bytes_q = {bytes_q, StartByte};
    if (bad_start) bytes_q[$urandom_range(1)] = StartByte ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 2 + IdLen; i++) begin
      b = 8'($urandom);
      bytes_q = {bytes_q, b};
      sum ^= b;
    end
    if (bad_enc) b = $urandom_range(1) ? 8'h00 : 8'($urandom_range(4, 255));
    else         b = 8'($urandom_range(EncMin, EncMax));
    bytes_q = {bytes_q, b};
    sum ^= b;
    bytes_q = {bytes_q, len[15:8]};
    bytes_q = {bytes_q, len[7:0]};
    sum ^= len[15:8] ^ len[7:0];
    // Build only as much payload as a truncated buffer will carry.
    for (int i = 0; i < len && (cut < 0 || bytes_q.size() <= cut); i++) begin
      b = 8'($urandom);
      bytes_q = {bytes_q, b};
      sum ^= b;
    end
    bytes_q = {bytes_q, (bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum)};
    if (cut >= 0 && cut < bytes_q.size()) begin
      bytes_q = bytes_q[0:cut];
    end else begin
      repeat (tail_len) bytes_q = {bytes_q, 8'($urandom)};
    end
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  task automatic send_noise(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_byte((i < 2 && $urandom_range(1)) ? StartByte : 8'($urandom), i == n - 1);
    end
  endtask

  task automatic send_random_buffer();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)      send_frame(0, 0, 0, $urandom_range(0, 12), -1, $urandom_range(0, 3));
    else if (pick < 60) send_frame(0, 0, 1, $urandom_range(0, 12), -1, $urandom_range(0, 2));
    else if (pick < 68) send_frame(0, 1, $urandom_range(1), $urandom_range(0, 8), -1,
                                   $urandom_range(0, 2));
    else if (pick < 75) send_frame(1, $urandom_range(1), 0, $urandom_range(0, 8),
                                   $urandom_range(1) ? -1 : int'($urandom_range(0, HeaderLen)),
                                   $urandom_range(0, 3));
    else if (pick < 90) send_frame(0, $urandom_range(1), 0, $urandom_range(0, 65535),
                                   $urandom_range(0, HeaderLen + 15), 0);
    else                send_noise($urandom_range(1, 30));
  endtask

  // Stop offering and hold until every expected item has come out, then let the pipe settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned target;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed buffers: shortest buffer, zero-length and full frames, every status.
    send_byte(StartByte, 1'b1);
    send_frame(0, 0, 0, 0, -1, 2);
    send_frame(0, 0, 0, 3, -1, 0);
    send_frame(1, 0, 0, 4, HeaderLen - 1, 0);          // bad start closing on the buffer end
    send_frame(1, 0, 0, 4, -1, 3);                     // bad start, trailing bytes dropped
    send_frame(1, 0, 0, 4, 9, 0);                      // short bad-start buffer reads truncated
    send_frame(0, 1, 1, 2, -1, 1);                     // bad encryption beats bad checksum
    send_frame(0, 0, 1, 5, -1, 0);
    send_frame(0, 0, 0, 6, HeaderLen + 5, 0);          // cut on the last payload byte
    send_frame(0, 0, 0, 64, -1, 1);
    wait_drained();

    // Random buffers under each idling pattern.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 75; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 75; end
        default: begin src_idle_pct = 33; snk_stall_pct = 33; end
      endcase
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_random_buffer();
      wait_drained();
    end

    // Back-pressure: hold the receiver off while a long frame keeps coming.
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_reqs++;
    send_frame(0, 0, 0, 60, -1, 0);
    wait_drained();

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("telematics_frame_deframer_tb: PASS");
    end else begin
      $display("telematics_frame_deframer_tb: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/tfd_pkg.sv
rtl/core/tfd_front.sv
rtl/core/tfd_queue.sv
rtl/core/tfd_back.sv
rtl/core/telematics_frame_deframer.sv
verif/telematics_frame_deframer_tb.sv
